// ===== hw/rtl/cpc_pkg.sv =====
package cpc_pkg;

   // Number of CORDIC micro-rotations, one pipeline stage each (8 to 32).
   localparam int ITERATIONS = 16;

   // Port field widths.
   localparam int IN_A_W = 17;
   localparam int IN_B_W = 16;
   localparam int OUT_W  = 17;

   // Datapath: coordinates carry GUARD extra fraction bits, angles are binary
   // angle units with 2^32 per turn plus one bit of headroom.
   localparam int GUARD = 12;
   localparam int XY_W  = 32;
   localparam int Z_W   = 33;

   localparam logic signed [Z_W-1:0] HALF_TURN    = 33'sh0_8000_0000;
   localparam logic signed [Z_W-1:0] QUARTER_TURN = 33'sh0_4000_0000;

   // Arctangent of 2^-i in binary angle units.
   localparam logic [31:0] ATAN_BAM [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef enum logic {
      MODE_TO_POLAR = 1'b0,
      MODE_TO_CART  = 1'b1
   } mode_type;

   // One item as it travels through the rotation stages.
   typedef struct packed {
      logic                   valid;
      mode_type               mode;
      logic                   zero;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_type;

endpackage

// ===== hw/rtl/cpc_cordic.sv =====
module cpc_cordic
   import cpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  cordic_type stage_in,
   output cordic_type stage_out
);

   cordic_type src      [ITERATIONS];
   cordic_type stage_ff [ITERATIONS];

   for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
      cordic_type             stage_in_k;
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic signed [Z_W-1:0]  atan_k;
      logic                   d;

      if (k == 0) begin : g_first
         assign src[k] = stage_in;
      end else begin : g_rest
         assign src[k] = stage_ff[k-1];
      end

      // Vectoring drives y toward zero, rotation drives z toward zero; both
      // reduce to the same add/subtract pattern once the direction is chosen.
      always_comb begin
         xs     = $signed(src[k].x) >>> k;
         ys     = $signed(src[k].y) >>> k;
         atan_k = $signed({1'b0, ATAN_BAM[k]});
         d      = (src[k].mode == MODE_TO_POLAR) ? !src[k].y[XY_W-1] : src[k].z[Z_W-1];
         stage_in_k = src[k];
         if (d) begin
            stage_in_k.x = src[k].x + ys;
            stage_in_k.y = src[k].y - xs;
            stage_in_k.z = src[k].z + atan_k;
         end else begin
            stage_in_k.x = src[k].x - ys;
            stage_in_k.y = src[k].y + xs;
            stage_in_k.z = src[k].z - atan_k;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else if (en) begin
            stage_ff[k] <= stage_in_k;
         end
      end
   end

   assign stage_out = stage_ff[ITERATIONS-1];

   // In vectoring the x coordinate starts non-negative and only grows.
   assert property (@(posedge clock) disable iff (reset)
      (stage_out.valid && stage_out.mode == MODE_TO_POLAR) |-> !stage_out.x[XY_W-1])
      else $error("cpc_cordic: negative x after vectoring");

endmodule

// ===== hw/rtl/cpc_out_fifo.sv =====
module cpc_out_fifo
   import cpc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic signed [OUT_W-1:0] push_first,
   input  logic signed [OUT_W-1:0] push_second,
   output logic                    full,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [OUT_W-1:0] out_first,
   output logic signed [OUT_W-1:0] out_second
);

   logic signed [OUT_W-1:0] first_ff  [2];
   logic signed [OUT_W-1:0] second_ff [2];
   logic                    wr_ptr_ff;
   logic                    wr_ptr_in;
   logic                    rd_ptr_ff;
   logic                    rd_ptr_in;
   logic [1:0]              count_ff;
   logic [1:0]              count_in;
   logic                    pop;

   assign full       = (count_ff == 2'd2);
   assign out_valid  = (count_ff != 2'd0);
   assign pop        = out_valid && out_ready;
   assign out_first  = first_ff[rd_ptr_ff];
   assign out_second = second_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         first_ff[wr_ptr_ff]  <= push_first;
         second_ff[wr_ptr_ff] <= push_second;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("cpc_out_fifo: write into a full buffer");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("cpc_out_fifo: fill level did not rise on a write");

endmodule

// ===== hw/rtl/cartesian_polar_converter.sv =====
// Cartesian/polar converter, fully pipelined CORDIC.
// Request channel (req_valid/req_ready): req_mode selects the conversion,
// 0 takes x and y and returns magnitude and atan2 angle in degrees,
// 1 takes radius and angle in degrees and returns x and y. Coordinates are
// signed with 8 fraction bits, angles are degrees with 7 fraction bits.
// Response channel (rsp_valid/rsp_ready) returns one result per request, in
// request order.
// From a request transfer to the earliest response transfer an item passes two
// stages of angle scaling, one setup stage, one stage per CORDIC iteration,
// two gain-correction stages (a 32x30 multiply) and a two-entry output buffer.
// Throughput: one request per cycle while req_ready is high, set by the
// one-stage-per-iteration pipeline.
// When the receiver stalls, results collect in the output buffer; the pipeline
// keeps moving until the buffer holds two results, then req_ready drops and
// the whole pipeline holds until a response transfer frees an entry.
// A synchronous reset empties the pipeline and the buffer.
module cartesian_polar_converter
   import cpc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_mode,
   input  logic signed [IN_A_W-1:0] req_first_operand,
   input  logic signed [IN_B_W-1:0] req_second_operand,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [OUT_W-1:0]  rsp_first_result,
   output logic signed [OUT_W-1:0]  rsp_second_result
);

   // Degrees (7 fraction bits) to binary angle units: d * 2^22 / 45, rounded.
   // 2^22 = 45 * 93206 + 34, so the quotient is split into an exact part and
   // a small remainder divided through a reciprocal.
   localparam int DEG_WHOLE       = 93206;
   localparam int DEG_REM         = 34;
   localparam int DEG_BIAS        = 22;
   localparam int DEG_V_W         = 21;
   localparam int DEG_RECIP_W     = 22;
   localparam int DEG_RECIP_SHIFT = 27;
   localparam int DEG_PROD_W      = DEG_V_W + DEG_RECIP_W;
   localparam int DEG_Q_W         = DEG_PROD_W - DEG_RECIP_SHIFT;
   localparam logic [DEG_RECIP_W-1:0] DEG_RECIP = 22'd2982617;

   // Gain correction: multiply by 1/K in Q30, drop Q30 and guard bits.
   localparam int GAIN_W      = 30;
   localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;
   localparam int PROD_W      = XY_W + GAIN_W;
   localparam int ROUND_SHIFT = GAIN_W + GUARD;
   localparam int MAG_W       = PROD_W + 1 - ROUND_SHIFT;
   localparam int COORD_MAX   = 65535;
   localparam int COORD_NEG   = 65536;

   // Binary angle units back to degrees: (|z| * 45 + 2^21) >> 22.
   localparam int ANG_SUM_W   = Z_W + 7;
   localparam int ANG_SHIFT   = 22;
   localparam int ANG_W       = ANG_SUM_W - ANG_SHIFT;
   localparam int ANGLE_LIMIT = 23040;

   typedef struct packed {
      mode_type                mode;
      logic signed [IN_A_W-1:0] a;
      logic signed [IN_B_W-1:0] b;
   } front_type;

   typedef struct packed {
      front_type          front;
      logic [31:0]        hi;
      logic [DEG_Q_W-1:0] lo_q;
   } scale_type;

   typedef struct packed {
      mode_type       mode;
      logic           zero;
      logic           sx;
      logic [XY_W-1:0] ax;
      logic           sy;
      logic [XY_W-1:0] ay;
      logic           sz;
      logic [Z_W-1:0] az;
   } abs_type;

   typedef struct packed {
      mode_type          mode;
      logic              zero;
      logic              sx;
      logic [PROD_W-1:0] px;
      logic              sy;
      logic [PROD_W-1:0] py;
      logic              sz;
      logic [ANG_W-1:0]  ang;
   } gain_type;

   function automatic logic signed [OUT_W-1:0] coord_out(input logic neg,
                                                         input logic [PROD_W-1:0] prod);
      logic [PROD_W:0]         half;
      logic [PROD_W:0]         sum;
      logic [MAG_W-1:0]        mag;
      logic signed [OUT_W-1:0] res;
      half              = '0;
      half[ROUND_SHIFT-1] = 1'b1;
      sum               = {1'b0, prod} + half;
      mag               = sum[PROD_W:ROUND_SHIFT];
      if (!neg) begin
         res = (mag > MAG_W'(COORD_MAX)) ? OUT_W'(COORD_MAX) : $signed(OUT_W'(mag));
      end else begin
         res = (mag > MAG_W'(COORD_NEG)) ? OUT_W'(-COORD_NEG) : -$signed(OUT_W'(mag));
      end
      return res;
   endfunction

   function automatic logic signed [OUT_W-1:0] angle_out(input logic neg,
                                                         input logic [ANG_W-1:0] ang);
      logic [ANG_W-1:0]        lim;
      logic signed [OUT_W-1:0] res;
      lim = (ang > ANG_W'(ANGLE_LIMIT)) ? ANG_W'(ANGLE_LIMIT) : ang;
      res = neg ? -$signed(OUT_W'(lim)) : $signed(OUT_W'(lim));
      return res;
   endfunction

   logic       en;
   logic       fifo_full;
   logic       push;

   logic       p1_valid_ff;
   front_type  p1_ff;
   logic       p2_valid_ff;
   scale_type  p2_ff;
   scale_type  p2_in;
   cordic_type c0_ff;
   cordic_type c0_in;
   cordic_type co;
   logic       f1_valid_ff;
   abs_type    f1_ff;
   abs_type    f1_in;
   logic       f2_valid_ff;
   gain_type   f2_ff;
   gain_type   f2_in;

   logic [IN_B_W-1:0]       abs_b;
   logic [DEG_V_W-1:0]      deg_v;
   logic [DEG_PROD_W-1:0]   deg_lo;
   logic [31:0]             deg_q;
   logic [31:0]             deg_t;
   logic signed [Z_W-1:0]   z_deg;
   logic signed [XY_W-1:0]  x_start;
   logic signed [XY_W-1:0]  y_start;
   logic [ANG_SUM_W-1:0]    ang_sum;
   logic signed [OUT_W-1:0] res_first;
   logic signed [OUT_W-1:0] res_second;

   // The whole pipeline moves together; the output buffer always has room
   // for the item leaving the last stage when it is not full.
   assign en        = !fifo_full;
   assign req_ready = en;
   assign push      = f2_valid_ff && en;

   // Stage 1: exact part and remainder product of the degree scaling.
   always_comb begin
      abs_b        = p1_ff.b[IN_B_W-1] ? (IN_B_W'(0) - p1_ff.b) : p1_ff.b;
      deg_v        = DEG_V_W'(abs_b) * DEG_V_W'(DEG_REM) + DEG_V_W'(DEG_BIAS);
      deg_lo       = deg_v * DEG_RECIP;
      p2_in.front  = p1_ff;
      p2_in.hi     = 32'(abs_b) * 32'(DEG_WHOLE);
      p2_in.lo_q   = deg_lo[DEG_PROD_W-1:DEG_RECIP_SHIFT];
   end

   // Stage 2: finish the angle, fold it into the right half-plane, or set up
   // vectoring by reflecting a vector with negative x.
   always_comb begin
      deg_q   = p2_ff.hi + 32'(p2_ff.lo_q);
      deg_t   = p2_ff.front.b[IN_B_W-1] ? (32'd0 - deg_q) : deg_q;
      z_deg   = $signed({deg_t[31], deg_t});
      x_start = $signed({{(XY_W-IN_A_W-GUARD){p2_ff.front.a[IN_A_W-1]}},
                         p2_ff.front.a, {GUARD{1'b0}}});
      y_start = $signed({{(XY_W-IN_B_W-GUARD){p2_ff.front.b[IN_B_W-1]}},
                         p2_ff.front.b, {GUARD{1'b0}}});
      c0_in.valid = p2_valid_ff;
      c0_in.mode  = p2_ff.front.mode;
      unique case (p2_ff.front.mode)
         MODE_TO_POLAR: begin
            c0_in.zero = (p2_ff.front.a == '0) && (p2_ff.front.b == '0);
            if (p2_ff.front.a[IN_A_W-1]) begin
               c0_in.z = p2_ff.front.b[IN_B_W-1] ? -HALF_TURN : HALF_TURN;
               c0_in.x = -x_start;
               c0_in.y = -y_start;
            end else begin
               c0_in.z = '0;
               c0_in.x = x_start;
               c0_in.y = y_start;
            end
         end
         MODE_TO_CART: begin
            c0_in.zero = 1'b0;
            c0_in.y    = '0;
            if (z_deg > QUARTER_TURN) begin
               c0_in.z = z_deg - HALF_TURN;
               c0_in.x = -x_start;
            end else if (z_deg < -QUARTER_TURN) begin
               c0_in.z = z_deg + HALF_TURN;
               c0_in.x = -x_start;
            end else begin
               c0_in.z = z_deg;
               c0_in.x = x_start;
            end
         end
         default: begin
            c0_in.zero = 1'b0;
            c0_in.x    = x_start;
            c0_in.y    = y_start;
            c0_in.z    = z_deg;
         end
      endcase
   end

   cpc_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .stage_in  (c0_ff),
      .stage_out (co)
   );

   // Magnitudes and signs ahead of the gain multiply and the angle scaling.
   always_comb begin
      f1_in.mode = co.mode;
      f1_in.zero = co.zero;
      f1_in.sx   = co.x[XY_W-1];
      f1_in.ax   = co.x[XY_W-1] ? (XY_W'(0) - co.x) : co.x;
      f1_in.sy   = co.y[XY_W-1];
      f1_in.ay   = co.y[XY_W-1] ? (XY_W'(0) - co.y) : co.y;
      f1_in.sz   = co.z[Z_W-1];
      f1_in.az   = co.z[Z_W-1] ? (Z_W'(0) - co.z) : co.z;
   end

   always_comb begin
      ang_sum    = ANG_SUM_W'(f1_ff.az) * ANG_SUM_W'(45) + (ANG_SUM_W'(1) << (ANG_SHIFT - 1));
      f2_in.mode = f1_ff.mode;
      f2_in.zero = f1_ff.zero;
      f2_in.sx   = f1_ff.sx;
      f2_in.px   = f1_ff.ax * INV_GAIN_Q30;
      f2_in.sy   = f1_ff.sy;
      f2_in.py   = f1_ff.ay * INV_GAIN_Q30;
      f2_in.sz   = f1_ff.sz;
      f2_in.ang  = ang_sum[ANG_SUM_W-1:ANG_SHIFT];
   end

   // Rounding, saturation and result selection feed the output buffer.
   always_comb begin
      if (f2_ff.zero) begin
         res_first  = '0;
         res_second = '0;
      end else begin
         res_first = coord_out(f2_ff.sx, f2_ff.px);
         unique case (f2_ff.mode)
            MODE_TO_POLAR: res_second = angle_out(f2_ff.sz, f2_ff.ang);
            MODE_TO_CART:  res_second = coord_out(f2_ff.sy, f2_ff.py);
            default:       res_second = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         c0_ff.valid <= 1'b0;
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= req_valid;
         p1_ff       <= '{mode: mode_type'(req_mode), a: req_first_operand,
                          b: req_second_operand};
         p2_valid_ff <= p1_valid_ff;
         p2_ff       <= p2_in;
         c0_ff       <= c0_in;
         f1_valid_ff <= co.valid;
         f1_ff       <= f1_in;
         f2_valid_ff <= f1_valid_ff;
         f2_ff       <= f2_in;
      end
   end

   cpc_out_fifo u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_first  (res_first),
      .push_second (res_second),
      .full        (fifo_full),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_first   (rsp_first_result),
      .out_second  (rsp_second_result)
   );

   // After folding, a rotation angle lies within a quarter turn of zero.
   assert property (@(posedge clock) disable iff (reset)
      (c0_ff.valid && c0_ff.mode == MODE_TO_CART) |->
         (c0_ff.z <= QUARTER_TURN) && (c0_ff.z >= -QUARTER_TURN))
      else $error("cartesian_polar_converter: rotation angle not folded");

   // The zero-vector shortcut exists only for cartesian to polar.
   assert property (@(posedge clock) disable iff (reset)
      (f2_valid_ff && f2_ff.zero) |-> f2_ff.mode == MODE_TO_POLAR)
      else $error("cartesian_polar_converter: zero flag on a rotation item");

endmodule

// ===== tb/sv/cartesian_polar_converter_test.sv =====
module cartesian_polar_converter_test
   import cpc_pkg::*;
;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int GUARD_BITS = 12;
   localparam longint INV_GAIN = 64'sd652032874;
   localparam longint TURN_HALF = 64'sd2147483648;
   localparam longint TURN_QUARTER = 64'sd1073741824;
   localparam longint ANGLE_LIMIT = 64'sd23040;
   localparam longint COORD_MAX = 64'sd65535;
   localparam longint COORD_MIN = -64'sd65536;

   // Arctangent of 2^-i, in units of 2^-32 turn.
   localparam longint ARCTAN_STEP [32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
      64'h00000001, 64'h00000000
   };

   typedef struct {
      logic signed [OUT_W-1:0] first_value;
      logic signed [OUT_W-1:0] second_value;
   } conversion_result_type;

   class conversion_scoreboard;
      conversion_result_type expected_results[$];
      int errors;

      // Removes the CORDIC gain and the guard bits, rounding half away from zero.
      function logic signed [OUT_W-1:0] gain_corrected(longint v);
         longint product, mag;
         product = v * INV_GAIN;
         mag = (product < 0) ? -product : product;
         mag = (mag + (longint'(1) << (29 + GUARD_BITS))) >> (30 + GUARD_BITS);
         if (product < 0) mag = -mag;
         if (mag > COORD_MAX) mag = COORD_MAX;
         if (mag < COORD_MIN) mag = COORD_MIN;
         return mag[OUT_W-1:0];
      endfunction

      function conversion_result_type convert(mode_type mode, logic signed [IN_A_W-1:0] a,
                                              logic signed [IN_B_W-1:0] b);
         longint x, y, z, nx, ny, mag;
         logic signed [31:0] wrapped;
         conversion_result_type r;
         x = longint'(a) * (longint'(1) << GUARD_BITS);
         if (mode == MODE_TO_POLAR) begin
            if (a == 0 && b == 0) begin
               r.first_value = '0;
               r.second_value = '0;
               return r;
            end
            y = longint'(b) * (longint'(1) << GUARD_BITS);
            z = 0;
            // Left half plane: start from half a turn and mirror the vector.
            if (x < 0) begin
               z = (y >= 0) ? TURN_HALF : -TURN_HALF;
               x = -x;
               y = -y;
            end
            for (int i = 0; i < ITERATIONS && i < 32; i++) begin
               if (y >= 0) begin
                  nx = x + (y >>> i);
                  ny = y - (x >>> i);
                  z += ARCTAN_STEP[i];
               end else begin
                  nx = x - (y >>> i);
                  ny = y + (x >>> i);
                  z -= ARCTAN_STEP[i];
               end
               x = nx;
               y = ny;
            end
            r.first_value = gain_corrected(x);
            mag = (z < 0) ? -z : z;
            mag = (mag * 45 + (longint'(1) << 21)) >> 22;
            if (z < 0) mag = -mag;
            if (mag > ANGLE_LIMIT) mag = ANGLE_LIMIT;
            if (mag < -ANGLE_LIMIT) mag = -ANGLE_LIMIT;
            r.second_value = mag[OUT_W-1:0];
         end else begin
            mag = (b < 0) ? -longint'(b) : longint'(b);
            mag = (mag * 4194304 + 22) / 45;
            if (b < 0) mag = -mag;
            // The angle wraps modulo a full turn.
            wrapped = mag[31:0];
            z = longint'(wrapped);
            y = 0;
            if (z > TURN_QUARTER) begin
               z -= TURN_HALF;
               x = -x;
            end else if (z < -TURN_QUARTER) begin
               z += TURN_HALF;
               x = -x;
            end
            for (int i = 0; i < ITERATIONS && i < 32; i++) begin
               if (z >= 0) begin
                  nx = x - (y >>> i);
                  ny = y + (x >>> i);
                  z -= ARCTAN_STEP[i];
               end else begin
                  nx = x + (y >>> i);
                  ny = y - (x >>> i);
                  z += ARCTAN_STEP[i];
               end
               x = nx;
               y = ny;
            end
            r.first_value = gain_corrected(x);
            r.second_value = gain_corrected(y);
         end
         return r;
      endfunction

      function void note_request(mode_type mode, logic signed [IN_A_W-1:0] a,
                                 logic signed [IN_B_W-1:0] b);
         expected_results.push_back(convert(mode, a, b));
      endfunction

      function void check_response(logic signed [OUT_W-1:0] first_value,
                                   logic signed [OUT_W-1:0] second_value);
         conversion_result_type want;
         if (expected_results.size() == 0) begin
            $error("response transfer with no request outstanding: %0d %0d",
                   first_value, second_value);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         if (first_value !== want.first_value) begin
            $error("first_result: expected %0d, got %0d", want.first_value, first_value);
            errors++;
         end
         if (second_value !== want.second_value) begin
            $error("second_result: expected %0d, got %0d", want.second_value, second_value);
            errors++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = 1'b0;
   logic signed [IN_A_W-1:0] req_first_operand = '0;
   logic signed [IN_B_W-1:0] req_second_operand = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_first_result;
   logic signed [OUT_W-1:0] rsp_second_result;

   conversion_scoreboard scoreboard = new();
   int cycle_count = 0;
   int stall_mode = 0;
   int stall_left = 0;

   cartesian_polar_converter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_first_operand(req_first_operand),
      .req_second_operand(req_second_operand),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_first_result(rsp_first_result),
      .rsp_second_result(rsp_second_result)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver: checks each response transfer and stalls on a changing pattern.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         scoreboard.check_response(rsp_first_result, rsp_second_result);
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= (cycle_count % 5 != 0);
      endcase
   end

   task automatic send_item(input mode_type mode, input logic signed [IN_A_W-1:0] a,
                            input logic signed [IN_B_W-1:0] b);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_first_operand <= a;
      req_second_operand <= b;
      do @(posedge clock); while (!req_ready);
      scoreboard.note_request(mode, a, b);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int burst;
      int gap;
      int next_drain;
      mode_type mode;
      logic signed [IN_A_W-1:0] a;
      logic signed [IN_B_W-1:0] b;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Vectoring corner cases: zero vector, axes, negative x on the axis,
      // saturated magnitude.
      send_item(MODE_TO_POLAR, 17'sd0, 16'sd0);
      send_item(MODE_TO_POLAR, 17'sd256, 16'sd0);
      send_item(MODE_TO_POLAR, -17'sd1280, 16'sd0);
      send_item(MODE_TO_POLAR, 17'sd0, 16'sd256);
      send_item(MODE_TO_POLAR, 17'sd0, -16'sd256);
      send_item(MODE_TO_POLAR, -17'sd256, -16'sd1);
      send_item(MODE_TO_POLAR, -17'sd65536, 16'sd0);
      send_item(MODE_TO_POLAR, 17'sd65535, 16'sd32767);
      send_item(MODE_TO_POLAR, -17'sd65536, -16'sd32768);
      send_item(MODE_TO_POLAR, 17'sd1, 16'sd1);
      send_item(MODE_TO_POLAR, -17'sd1, 16'sd1);
      // Rotation: quadrant boundaries, wrap beyond half a turn, negative radius.
      send_item(MODE_TO_CART, 17'sd256, 16'sd0);
      send_item(MODE_TO_CART, 17'sd256, 16'sd11520);
      send_item(MODE_TO_CART, 17'sd256, 16'sd23040);
      send_item(MODE_TO_CART, 17'sd256, -16'sd23040);
      send_item(MODE_TO_CART, 17'sd25600, 16'sd32767);
      send_item(MODE_TO_CART, 17'sd25600, -16'sd32768);
      send_item(MODE_TO_CART, -17'sd65536, 16'sd5760);
      send_item(MODE_TO_CART, 17'sd65535, 16'sd5760);
      send_item(MODE_TO_CART, 17'sd0, 16'sd1234);
      send_item(MODE_TO_CART, -17'sd256, -16'sd11520);
      wait_for_drain();

      sent = 0;
      next_drain = 350;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            mode = mode_type'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
               0: a = IN_A_W'($urandom);
               1: a = IN_A_W'($urandom_range(0, 92682) - 46341);
               2: a = IN_A_W'($urandom_range(0, 2048) - 1024);
               default:
                  case ($urandom_range(0, 4))
                     0: a = -17'sd65536;
                     1: a = 17'sd65535;
                     2: a = 17'sd0;
                     3: a = 17'sd1;
                     default: a = -17'sd1;
                  endcase
            endcase
            case ($urandom_range(0, 3))
               0, 1: b = IN_B_W'($urandom);
               2: b = IN_B_W'($urandom_range(0, 1024) - 512);
               // Exact axes and multiples of 45 degrees, one step either side.
               default: b = (mode == MODE_TO_POLAR) ? 16'sd0 :
                            16'(($urandom_range(0, 10) - 5) * 5760 +
                                $urandom_range(0, 2) - 1);
            endcase
            send_item(mode, a, b);
            sent++;
         end
         if (sent >= next_drain) begin
            wait_for_drain();
            next_drain += 350;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;

      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (2 * ITERATIONS + 12) @(posedge clock);
      if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
